[rtl/core/vdms_pkg.sv]
// shared types, codes and constants of the drive mode supervisor
package vdms_pkg;

    localparam int VDMS_QUEUE_DEPTH = 4;

    localparam int DATA_W    = 16;
    localparam int ELAPSED_W = 32;
    localparam int CFG_IDX_W = 3;

    // event kinds
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_HOST     = 2'd1;
    localparam logic [1:0] CMD_DISTANCE = 2'd2;
    localparam logic [1:0] CMD_TAKEOVER = 2'd3;

    // drive modes
    localparam logic [1:0] MODE_MANUAL       = 2'd0;
    localparam logic [1:0] MODE_AUTO         = 2'd1;
    localparam logic [1:0] MODE_AUTO_ABORT   = 2'd2;
    localparam logic [1:0] MODE_MANUAL_ABORT = 2'd3;

    // requested modes
    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_MANUAL = 2'd1;
    localparam logic [1:0] REQ_AUTO   = 2'd2;

    // host client modes
    localparam logic [1:0] CLIENT_ABSENT = 2'd0;
    localparam logic [1:0] CLIENT_MANUAL = 2'd1;

    // stop reasons
    localparam logic [2:0] STOP_NONE     = 3'd0;
    localparam logic [2:0] STOP_BUTTON   = 3'd1;
    localparam logic [2:0] STOP_TAKEOVER = 3'd2;
    localparam logic [2:0] STOP_COMM     = 3'd3;
    localparam logic [2:0] STOP_OBSTACLE = 3'd4;

    // reject reasons
    localparam logic [2:0] REJ_NONE       = 3'd0;
    localparam logic [2:0] REJ_OBSTACLE   = 3'd1;
    localparam logic [2:0] REJ_MAN_ABORT  = 3'd2;
    localparam logic [2:0] REJ_MISMATCH   = 3'd3;
    localparam logic [2:0] REJ_IN_TAKEOVER = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMM_TIMEOUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADMAN_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_CLEAR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENTRY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_ABORT  = 3'd4;

    // register reset values
    localparam logic [DATA_W-1:0] COMM_TIMEOUT_RST    = 16'd1500;
    localparam logic [DATA_W-1:0] DEADMAN_TIMEOUT_RST = 16'd300;
    localparam logic [DATA_W-1:0] RESET_CLEAR_RST     = 16'd200;
    localparam logic [DATA_W-1:0] AUTO_ENTRY_RST      = 16'd300;
    localparam logic [DATA_W-1:0] OBSTACLE_ABORT_RST  = 16'd100;

    localparam logic [DATA_W-1:0] DISTANCE_RST = 16'd1200;

    // q2.14 limits
    localparam logic signed [DATA_W-1:0] Q_ONE     = 16'sd16384;
    localparam logic signed [DATA_W-1:0] Q_NEG_ONE = -16'sd16384;

    typedef struct packed {
        logic [DATA_W-1:0] link_loss_ms;
        logic [DATA_W-1:0] idle_drive_ms;
        logic [DATA_W-1:0] reset_clear_distance_mm;
        logic [DATA_W-1:0] auto_entry_distance_mm;
        logic [DATA_W-1:0] obstacle_abort_distance_mm;
    } vdms_cfg_t;

    // classified event as it travels through the queue
    typedef struct packed {
        logic [1:0]               kind;
        logic                     abort_req;
        logic                     reset_req;
        logic [1:0]               target;
        logic                     client_ok;
        logic signed [DATA_W-1:0] throttle;
        logic signed [DATA_W-1:0] steering;
        logic [DATA_W-1:0]        arg;
    } vdms_op_t;

endpackage

[rtl/core/vdms_if.sv]
// event and result channel interfaces
interface vdms_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic               abort_request;
    logic               reset_request;
    logic [1:0]         mode_sel;
    logic [1:0]         host_role;
    logic signed [15:0] throttle_in;
    logic signed [15:0] steering_in;
    logic [15:0]        distance_in_mm;
    logic [15:0]        time_step_ms;
    logic [15:0]        takeover_duration_ms;

    modport source (
        output valid, command, abort_request, reset_request, mode_sel, host_role,
        output throttle_in, steering_in, distance_in_mm, time_step_ms, takeover_duration_ms,
        input  ready
    );
    modport sink (
        input  valid, command, abort_request, reset_request, mode_sel, host_role,
        input  throttle_in, steering_in, distance_in_mm, time_step_ms, takeover_duration_ms,
        output ready
    );
endinterface

interface vdms_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic               takeover_active;
    logic [15:0]        takeover_left_ms;
    logic [2:0]         halt_cause;
    logic [2:0]         reject_reason;
    logic signed [15:0] throttle_out;
    logic signed [15:0] steering_out;
    logic [15:0]        distance_out_mm;

    modport source (
        output valid, mode, takeover_active, takeover_left_ms, halt_cause, reject_reason,
        output throttle_out, steering_out, distance_out_mm,
        input  ready
    );
    modport sink (
        input  valid, mode, takeover_active, takeover_left_ms, halt_cause, reject_reason,
        input  throttle_out, steering_out, distance_out_mm,
        output ready
    );
endinterface

[rtl/core/vdms_front.sv]
// front end: takes event words, decodes and clamps them for the queue
module vdms_front (
    vdms_in_if.sink         item,
    output logic            push_valid,
    input  logic            push_ready,
    output vdms_pkg::vdms_op_t push_word
);
    import vdms_pkg::*;

    logic signed [DATA_W-1:0] throttle_clamped;
    logic signed [DATA_W-1:0] steering_clamped;

    always_comb
    begin
        if (item.throttle_in > Q_ONE)
            throttle_clamped = Q_ONE;
        else if (item.throttle_in < Q_NEG_ONE)
            throttle_clamped = Q_NEG_ONE;
        else
            throttle_clamped = item.throttle_in;

        if (item.steering_in > Q_ONE)
            steering_clamped = Q_ONE;
        else if (item.steering_in < Q_NEG_ONE)
            steering_clamped = Q_NEG_ONE;
        else
            steering_clamped = item.steering_in;
    end

    always_comb
    begin
        push_word.kind      = item.command;
        push_word.abort_req = item.abort_request;
        push_word.reset_req = item.reset_request;
        // an unknown request code counts as no request
        if (item.mode_sel == REQ_MANUAL || item.mode_sel == REQ_AUTO)
            push_word.target = item.mode_sel;
        else
            push_word.target = REQ_NONE;
        push_word.client_ok = (item.host_role == CLIENT_ABSENT) ||
                              (item.host_role == CLIENT_MANUAL);
        push_word.throttle  = throttle_clamped;
        push_word.steering  = steering_clamped;
        // one argument word per event kind
        case (item.command)
            CMD_TICK:     push_word.arg = item.time_step_ms;
            CMD_DISTANCE: push_word.arg = item.distance_in_mm;
            CMD_TAKEOVER: push_word.arg = item.takeover_duration_ms;
            default:      push_word.arg = item.time_step_ms;
        endcase
    end

    assign push_valid = item.valid;
    assign item.ready = push_ready;

endmodule

[rtl/core/vdms_queue.sv]
// small register queue between front and back end
module vdms_queue #(
    parameter int DEPTH = vdms_pkg::VDMS_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  vdms_pkg::vdms_op_t push_word,
    output logic               pop_valid,
    input  logic               pop_ready,
    output vdms_pkg::vdms_op_t pop_word
);
    import vdms_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vdms_op_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_word;
    end

endmodule

[rtl/core/vdms_back.sv]
// back end: supervisor state update and result register
module vdms_back (
    input  logic                clk,
    input  logic                rst_n,
    input  vdms_pkg::vdms_cfg_t cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  vdms_pkg::vdms_op_t  pop_word,
    vdms_out_if.source          result
);
    import vdms_pkg::*;

    logic [1:0]               mode_reg, mode_next;
    logic                     tko_flag_reg, tko_flag_next;
    logic [DATA_W-1:0]        tko_left_reg, tko_left_next;
    logic [2:0]               stop_reg, stop_next;
    logic [2:0]               reject_reg, reject_next;
    logic signed [DATA_W-1:0] throttle_reg, throttle_next;
    logic signed [DATA_W-1:0] steering_reg, steering_next;
    logic [DATA_W-1:0]        dist_reg, dist_next;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic                     seen_reg, seen_next;
    logic                     out_valid_reg, out_valid_next;

    logic [ELAPSED_W:0]       elapsed_sum;
    logic                     do_pop;

    // state only moves when the result register is free, so it doubles as the result
    assign pop_ready = !out_valid_reg || result.ready;
    assign do_pop    = pop_valid && pop_ready;

    assign elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(pop_word.arg);

    always_comb
    begin
        mode_next     = mode_reg;
        tko_flag_next = tko_flag_reg;
        tko_left_next = tko_left_reg;
        stop_next     = stop_reg;
        reject_next   = reject_reg;
        throttle_next = throttle_reg;
        steering_next = steering_reg;
        dist_next     = dist_reg;
        elapsed_next  = elapsed_reg;
        seen_next     = seen_reg;

        case (pop_word.kind)
            CMD_TICK:
            begin
                if (tko_flag_reg && tko_left_reg != '0)
                begin
                    if (pop_word.arg >= tko_left_reg)
                    begin
                        mode_next     = MODE_AUTO_ABORT;
                        stop_next     = STOP_TAKEOVER;
                        tko_flag_next = 1'b0;
                        tko_left_next = '0;
                        throttle_next = '0;
                        steering_next = '0;
                    end
                    else
                        tko_left_next = tko_left_reg - pop_word.arg;
                end
                // saturating elapsed time
                elapsed_next = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
                if (seen_reg)
                begin
                    if ((mode_next == MODE_MANUAL || mode_next == MODE_AUTO) &&
                        elapsed_next > ELAPSED_W'(cfg.link_loss_ms))
                    begin
                        mode_next     = MODE_AUTO_ABORT;
                        stop_next     = STOP_COMM;
                        tko_flag_next = 1'b0;
                        tko_left_next = '0;
                        throttle_next = '0;
                        steering_next = '0;
                    end
                    if (mode_next == MODE_MANUAL &&
                        elapsed_next > ELAPSED_W'(cfg.idle_drive_ms))
                    begin
                        throttle_next = '0;
                        steering_next = '0;
                    end
                end
            end
            CMD_HOST:
            begin
                elapsed_next = '0;
                seen_next    = 1'b1;
                if (pop_word.abort_req)
                begin
                    mode_next     = MODE_MANUAL_ABORT;
                    stop_next     = STOP_BUTTON;
                    tko_flag_next = 1'b0;
                    tko_left_next = '0;
                    reject_next   = REJ_NONE;
                    throttle_next = '0;
                    steering_next = '0;
                end
                else if (pop_word.reset_req)
                begin
                    if (mode_reg == MODE_AUTO_ABORT || mode_reg == MODE_MANUAL_ABORT)
                    begin
                        if (dist_reg > cfg.reset_clear_distance_mm)
                        begin
                            mode_next     = MODE_MANUAL;
                            stop_next     = STOP_NONE;
                            reject_next   = REJ_NONE;
                            tko_flag_next = 1'b0;
                            tko_left_next = '0;
                            throttle_next = '0;
                            steering_next = '0;
                        end
                        else
                            reject_next = REJ_OBSTACLE;
                    end
                end
                else
                begin
                    if (pop_word.target != REQ_NONE)
                    begin
                        if (mode_reg == MODE_MANUAL_ABORT)
                            reject_next = REJ_MAN_ABORT;
                        else if (mode_reg == MODE_AUTO_ABORT)
                            reject_next = REJ_MISMATCH;
                        else if (pop_word.target == REQ_AUTO)
                        begin
                            if (tko_flag_reg)
                                reject_next = REJ_IN_TAKEOVER;
                            else if (mode_reg == MODE_MANUAL)
                            begin
                                if (dist_reg > cfg.auto_entry_distance_mm)
                                begin
                                    mode_next   = MODE_AUTO;
                                    reject_next = REJ_NONE;
                                end
                                else
                                    reject_next = REJ_OBSTACLE;
                            end
                            else
                                reject_next = REJ_MISMATCH;
                        end
                        else
                        begin
                            mode_next     = MODE_MANUAL;
                            tko_flag_next = 1'b0;
                            tko_left_next = '0;
                            reject_next   = REJ_NONE;
                        end
                    end
                    // drive values apply only in manual with a manual or absent client
                    if (mode_next == MODE_MANUAL && pop_word.client_ok)
                    begin
                        throttle_next = pop_word.throttle;
                        steering_next = pop_word.steering;
                    end
                    else
                    begin
                        throttle_next = '0;
                        steering_next = '0;
                    end
                end
            end
            CMD_DISTANCE:
            begin
                dist_next = pop_word.arg;
                if (mode_reg == MODE_AUTO && pop_word.arg < cfg.obstacle_abort_distance_mm)
                begin
                    mode_next     = MODE_AUTO_ABORT;
                    stop_next     = STOP_OBSTACLE;
                    tko_flag_next = 1'b0;
                    tko_left_next = '0;
                    throttle_next = '0;
                    steering_next = '0;
                end
            end
            CMD_TAKEOVER:
            begin
                if (mode_reg == MODE_AUTO)
                begin
                    tko_flag_next = 1'b1;
                    tko_left_next = pop_word.arg;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        if (do_pop)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_MANUAL;
            tko_flag_reg  <= 1'b0;
            tko_left_reg  <= '0;
            stop_reg      <= STOP_NONE;
            reject_reg    <= REJ_NONE;
            throttle_reg  <= '0;
            steering_reg  <= '0;
            dist_reg      <= DISTANCE_RST;
            elapsed_reg   <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (do_pop)
            begin
                mode_reg     <= mode_next;
                tko_flag_reg <= tko_flag_next;
                tko_left_reg <= tko_left_next;
                stop_reg     <= stop_next;
                reject_reg   <= reject_next;
                throttle_reg <= throttle_next;
                steering_reg <= steering_next;
                dist_reg     <= dist_next;
                elapsed_reg  <= elapsed_next;
                seen_reg     <= seen_next;
            end
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.mode             = mode_reg;
    assign result.takeover_active  = tko_flag_reg;
    assign result.takeover_left_ms = tko_left_reg;
    assign result.halt_cause       = stop_reg;
    assign result.reject_reason    = reject_reg;
    assign result.throttle_out     = throttle_reg;
    assign result.steering_out     = steering_reg;
    assign result.distance_out_mm  = dist_reg;

endmodule

[rtl/core/vehicle_drive_mode_supervisor_core.sv]
// top level of the drive mode supervisor: config registers, front, queue, back
//
//   channel   dir   handshake       word
//   item      in    valid/ready     one event: tick, host command, distance, takeover
//   result    out   valid/ready     state after the event, one per item
//   cfg       in    cfg_we          register write, index and 16-bit data
//
// one item per cycle sustained while result.ready stays high; the back end updates all state together
// an accepted item is first written into the queue, then popped into the back end state
// registers, which drive the result
// rst_n clears mode, countdown, reasons, drive values and elapsed time, loads config defaults
// a QUEUE_DEPTH word queue absorbs result stalls; item.ready drops when it is full
module vehicle_drive_mode_supervisor_core #(
    parameter int QUEUE_DEPTH = vdms_pkg::VDMS_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    vdms_in_if.sink                          item,
    vdms_out_if.source                       result,
    input  logic                             cfg_we,
    input  logic [vdms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vdms_pkg::DATA_W-1:0]      cfg_data
);
    import vdms_pkg::*;

    vdms_cfg_t cfg_reg;
    vdms_op_t  push_word;
    vdms_op_t  pop_word;
    logic      push_valid;
    logic      push_ready;
    logic      pop_valid;
    logic      pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_loss_ms               <= COMM_TIMEOUT_RST;
            cfg_reg.idle_drive_ms              <= DEADMAN_TIMEOUT_RST;
            cfg_reg.reset_clear_distance_mm    <= RESET_CLEAR_RST;
            cfg_reg.auto_entry_distance_mm     <= AUTO_ENTRY_RST;
            cfg_reg.obstacle_abort_distance_mm <= OBSTACLE_ABORT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMM_TIMEOUT:    cfg_reg.link_loss_ms               <= cfg_data;
                CFG_DEADMAN_TIMEOUT: cfg_reg.idle_drive_ms              <= cfg_data;
                CFG_RESET_CLEAR:     cfg_reg.reset_clear_distance_mm    <= cfg_data;
                CFG_AUTO_ENTRY:      cfg_reg.auto_entry_distance_mm     <= cfg_data;
                CFG_OBSTACLE_ABORT:  cfg_reg.obstacle_abort_distance_mm <= cfg_data;
                default:             cfg_reg                            <= cfg_reg;
            endcase
        end
    end

    vdms_front u_front (
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    vdms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    vdms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .result    (result)
    );

endmodule
